// ----- rtl/wildcard_byte_pattern_search_unit_macros.svh -----
// Assertion macros for the wildcard byte pattern search unit.
// WBPS_ASSERT_IMP: same-cycle implication. WBPS_ASSERT_NXT: next-cycle implication.
`ifndef WILDCARD_BYTE_PATTERN_SEARCH_UNIT_MACROS_SVH
`define WILDCARD_BYTE_PATTERN_SEARCH_UNIT_MACROS_SVH
`ifndef SYNTHESIS
`define WBPS_ASSERT_IMP(name, clk, rst_n, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed");
`define WBPS_ASSERT_NXT(name, clk, rst_n, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");
`else
`define WBPS_ASSERT_IMP(name, clk, rst_n, ante, cons)
`define WBPS_ASSERT_NXT(name, clk, rst_n, ante, cons)
`endif
`endif

// ----- rtl/wbps_pkg.sv -----
package wbps_pkg;

	localparam int CFG_DATA_W = 64;
	localparam int CFG_ADDR_W = 4;
	// register index sits at paddr[3] (8-byte spacing)
	localparam logic REG_IMAGE_BASE = 1'b0;

	localparam logic ACT_PATTERN = 1'b0;
	localparam logic ACT_IMAGE   = 1'b1;

	typedef struct packed {
		logic       action;
		logic [7:0] byte_value;
		logic       is_wildcard;
		logic       last;
	} item_t;

	typedef struct packed {
		logic        found;
		logic [31:0] match_offset;
		logic [63:0] match_address;
	} result_t;

	typedef struct packed {
		logic accept;    // item transaction this cycle
		logic eval;      // resolve match for the most recent image byte
		logic load_out;  // write result register
	} cmd_t;

	typedef struct packed {
		logic result_pending;
	} sts_t;

endpackage

// ----- rtl/wbps_ctrl.sv -----
`include "wildcard_byte_pattern_search_unit_macros.svh"

module wbps_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           item_valid,
	input  logic           item_action,
	input  logic           result_ready,
	input  wbps_pkg::sts_t sts,
	output logic           item_ready,
	output logic           result_valid,
	output wbps_pkg::cmd_t cmd
);

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_EVAL = 2'd1;
	localparam logic [1:0] ST_SUM  = 2'd2;

	logic [1:0] state_q;
	logic [1:0] state_d;
	logic       result_valid_q;

	always_comb begin
		state_d      = state_q;
		item_ready   = 1'b0;
		cmd.accept   = 1'b0;
		cmd.eval     = 1'b0;
		cmd.load_out = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				item_ready = 1'b1;
				cmd.accept = item_valid;
				if (item_valid && item_action == wbps_pkg::ACT_IMAGE) begin
					state_d = ST_EVAL;
				end
			end
			ST_EVAL: begin
				cmd.eval = 1'b1;
				state_d  = sts.result_pending ? ST_SUM : ST_IDLE;
			end
			ST_SUM: begin
				if (!result_valid_q || result_ready) begin
					cmd.load_out = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= ST_IDLE;
			result_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.load_out) begin
				result_valid_q <= 1'b1;
			end else if (result_ready) begin
				result_valid_q <= 1'b0;
			end
		end
	end

	assign result_valid = result_valid_q;

	`WBPS_ASSERT_NXT(a_image_goes_eval, clk, arst_n, cmd.accept && item_action, state_q == ST_EVAL)
	`WBPS_ASSERT_IMP(a_load_when_free, clk, arst_n, cmd.load_out, !result_valid_q || result_ready)
	`WBPS_ASSERT_NXT(a_load_sets_valid, clk, arst_n, cmd.load_out, result_valid_q)

endmodule

// ----- rtl/wbps_dp.sv -----
module wbps_dp #(
	parameter int MAX_PATTERN = 64,
	parameter int OFFSET_BITS = 32
) (
	input  logic              clk,
	input  logic              arst_n,
	input  wbps_pkg::item_t   item,
	input  logic [63:0]       image_base,
	input  wbps_pkg::cmd_t    cmd,
	output wbps_pkg::sts_t    sts,
	output wbps_pkg::result_t result
);

	localparam int LEN_W = $clog2(MAX_PATTERN + 1);
	localparam int IDX_W = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;
	localparam int SUM_W = OFFSET_BITS + LEN_W;

	// signature store: each entry feeds its own comparator
	logic [7:0]             pat_byte_q [MAX_PATTERN];
	logic                   pat_wild_q [MAX_PATTERN];
	logic [LEN_W-1:0]       len_q;
	logic                   loaded_q;

	// scan state
	logic [MAX_PATTERN-1:0] pm_q;
	logic [OFFSET_BITS-1:0] seen_q;
	logic                   rep_q;

	// per-byte stage
	logic [OFFSET_BITS-1:0] seen_s1;
	logic                   search_s1;
	logic                   last_s1;

	// resolved result
	logic                   res_found_q;
	logic [OFFSET_BITS-1:0] res_off_q;

	logic                   is_img;
	logic                   clr;
	logic [LEN_W-1:0]       len_eff;
	logic [MAX_PATTERN-1:0] pm_eff;
	logic [MAX_PATTERN-1:0] pm_next;
	logic [OFFSET_BITS-1:0] seen_eff;
	logic                   rep_eff;
	logic                   seen_ok;
	logic                   search_en;
	logic                   wr_en;
	logic [LEN_W-1:0]       len_m1;
	logic                   hit;
	logic [SUM_W-1:0]       off_wide;

	assign is_img = (item.action == wbps_pkg::ACT_IMAGE);

	// a pattern element after a finished load starts a new signature;
	// an image byte during a load ends it; both drop the scan in progress
	always_comb begin
		clr      = is_img ? !loaded_q : loaded_q;
		len_eff  = (!is_img && loaded_q) ? '0 : len_q;
		pm_eff   = clr ? '0 : pm_q;
		seen_eff = clr ? '0 : seen_q;
		rep_eff  = clr ? 1'b0 : rep_q;
		seen_ok  = (seen_eff != {OFFSET_BITS{1'b1}});
		search_en = !rep_eff && seen_ok && (len_q != '0);
		wr_en    = (len_eff < LEN_W'(MAX_PATTERN));
		for (int k = 0; k < MAX_PATTERN; k++) begin
			pm_next[k] = ((k == 0) ? 1'b1 : pm_eff[(k == 0) ? 0 : k - 1])
				&& (pat_wild_q[k] || pat_byte_q[k] == item.byte_value);
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.accept && !is_img && wr_en) begin
			pat_byte_q[len_eff[IDX_W-1:0]] <= item.byte_value;
			pat_wild_q[len_eff[IDX_W-1:0]] <= item.is_wildcard;
		end
	end

	assign len_m1   = len_q - LEN_W'(1);
	assign hit      = search_s1 && pm_q[len_m1[IDX_W-1:0]];
	assign off_wide = SUM_W'(seen_s1) + SUM_W'(1) - SUM_W'(len_q);
	assign sts.result_pending = hit || (last_s1 && !rep_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_q    <= '0;
			loaded_q <= 1'b1;
			pm_q     <= '0;
			seen_q   <= '0;
			rep_q    <= 1'b0;
		end else if (cmd.accept) begin
			if (!is_img) begin
				if (wr_en) begin
					len_q <= len_eff + LEN_W'(1);
				end else begin
					len_q <= len_eff;
				end
				loaded_q <= item.last;
				pm_q     <= pm_eff;
				seen_q   <= seen_eff;
				rep_q    <= rep_eff;
			end else begin
				loaded_q <= 1'b1;
				pm_q     <= search_en ? pm_next : pm_eff;
				seen_q   <= seen_ok ? seen_eff + OFFSET_BITS'(1) : seen_eff;
				rep_q    <= rep_eff;
			end
		end else if (cmd.eval) begin
			if (last_s1) begin
				pm_q   <= '0;
				seen_q <= '0;
				rep_q  <= 1'b0;
			end else if (hit) begin
				rep_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			seen_s1   <= seen_eff;
			search_s1 <= search_en;
			last_s1   <= item.last;
		end
		if (cmd.eval) begin
			res_found_q <= hit;
			res_off_q   <= hit ? off_wide[OFFSET_BITS-1:0] : '0;
		end
		if (cmd.load_out) begin
			result.found         <= res_found_q;
			result.match_offset  <= 32'(res_off_q);
			result.match_address <= res_found_q ? image_base + 64'(res_off_q) : '0;
		end
	end

endmodule

// ----- rtl/wildcard_byte_pattern_search_unit.sv -----
// Channel   Handshake                    Payload            Direction
// item      item_valid / item_ready      wbps_pkg::item_t   in
// result    result_valid / result_ready  wbps_pkg::result_t out
// config    psel/penable/pwrite/pready   paddr, pwdata      in (prdata out)
//
// A pattern element is taken in IDLE. An image byte passes accept and match
// resolve (EVAL) when it gives no result, plus SUM (the 64-bit base add into
// the result register) when it does; eval decides which. Items wait for IDLE.
// Reset clears all control and scan state; the signature store is not cleared.
// A full result register stalls only an item that produces a new result.
module wildcard_byte_pattern_search_unit #(
	parameter int MAX_PATTERN = 64,
	parameter int OFFSET_BITS = 32
) (
	input  logic                              clk,
	input  logic                              arst_n,
	// APB-style configuration
	input  logic                              psel,
	input  logic                              penable,
	input  logic                              pwrite,
	input  logic [wbps_pkg::CFG_ADDR_W-1:0]   paddr,
	input  logic [wbps_pkg::CFG_DATA_W-1:0]   pwdata,
	output logic [wbps_pkg::CFG_DATA_W-1:0]   prdata,
	output logic                              pready,
	// input transactions: pattern elements and image bytes
	input  logic                              item_valid,
	output logic                              item_ready,
	input  wbps_pkg::item_t                   item,
	// output transactions: one per scan
	output logic                              result_valid,
	input  logic                              result_ready,
	output wbps_pkg::result_t                 result
);

	logic [63:0]    image_base_q;
	logic           reg_sel;
	wbps_pkg::cmd_t cmd;
	wbps_pkg::sts_t sts;

	// Only register: image_base at byte address 0 (index in paddr[3]).
	assign pready  = 1'b1;
	assign reg_sel = (paddr[3] == wbps_pkg::REG_IMAGE_BASE);
	assign prdata  = reg_sel ? image_base_q : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			image_base_q <= '0;
		end else if (psel && penable && pwrite && pready && reg_sel) begin
			image_base_q <= pwdata;
		end
	end

	// Controller: sequences accept, match resolve and result load.
	wbps_ctrl u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_action  (item.action),
		.result_ready (result_ready),
		.sts          (sts),
		.item_ready   (item_ready),
		.result_valid (result_valid),
		.cmd          (cmd)
	);

	// Datapath: signature store, shift-and match vector, offset and address.
	wbps_dp #(
		.MAX_PATTERN (MAX_PATTERN),
		.OFFSET_BITS (OFFSET_BITS)
	) u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.item       (item),
		.image_base (image_base_q),
		.cmd        (cmd),
		.sts        (sts),
		.result     (result)
	);

endmodule
